// ===== sv/rpfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rpfd_pkg;
   localparam int MAX_CHANNELS_DEF = 16;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_EDGE = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_MIN_OUTPUT  = 3'd0,
      REG_MAX_OUTPUT  = 3'd1,
      REG_MIN_PULSE   = 3'd2,
      REG_MAX_PULSE   = 3'd3,
      REG_CHAN_COUNT  = 3'd4,
      REG_THROTTLE    = 3'd5,
      REG_FRAME_GAP   = 3'd6,
      REG_SHORT_LIMIT = 3'd7
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   // front to back: one classified transaction
   typedef struct packed {
      logic        is_map;
      logic        frame_done;
      logic        failsafe;
      logic [15:0] value;
   } job_type;

   localparam logic [15:0] FAILSAFE_VALUE = 16'hFFFF;
endpackage
`default_nettype wire

// ===== sv/rc_ppm_frame_decoder.sv =====
// RC PPM frame decoder.
// req_ channel: push req_operation/req_channel_index while full is low.
//   Ticks and edges update the interval counter and channel banks at once;
//   reads look up the completed bank and are classified in the same cycle.
// A two-entry queue carries each classified transaction to the mapping unit.
// Ticks, edges, failsafe and out-of-range reads skip the mapping unit.
// A mapped read goes through one 17x17 multiply, then a
//   34-step restoring divider (one quotient bit per cycle) and saturation.
// rsp_ channel: result held while empty is low; pop takes it. If pop stays
//   low, the queue fills and full rises, holding back further pushes.
// csr_ port: csr_write_enable/csr_index/csr_write_data, written only while
//   idle (a user rule, not enforced). Reset restores register defaults,
//   clears counter, pointer and both banks; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module rc_ppm_frame_decoder #(
   parameter int MAX_CHANNELS = rpfd_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_operation,
   input  wire logic [3:0]  req_channel_index,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_frame_done,
   output logic [15:0]      rsp_channel_value,
   output logic             rsp_failsafe,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import rpfd_pkg::*;

   logic [15:0] min_out_ff, max_out_ff, min_pulse_ff, max_pulse_ff;
   logic [15:0] gap_ff, short_ff;
   logic [4:0]  count_ff, throttle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_out_ff   <= 16'd0;
         max_out_ff   <= 16'd1000;
         min_pulse_ff <= 16'd1000;
         max_pulse_ff <= 16'd2000;
         count_ff     <= 5'd8;
         throttle_ff  <= 5'd3;
         gap_ff       <= 16'd6000;
         short_ff     <= 16'd800;
      end else if (csr_write_enable) begin
         case (reg_type'(csr_index))
            REG_MIN_OUTPUT:  min_out_ff   <= csr_write_data;
            REG_MAX_OUTPUT:  max_out_ff   <= csr_write_data;
            REG_MIN_PULSE:   min_pulse_ff <= csr_write_data;
            REG_MAX_PULSE:   max_pulse_ff <= csr_write_data;
            REG_CHAN_COUNT:  count_ff     <= csr_write_data[4:0];
            REG_THROTTLE:    throttle_ff  <= csr_write_data[4:0];
            REG_FRAME_GAP:   gap_ff       <= csr_write_data;
            REG_SHORT_LIMIT: short_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   job_type job, q_job;
   logic    take, q_valid, q_ready, r_valid;

   assign take = push && !full;

   rpfd_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock, .reset, .take, .op(req_operation), .idx(req_channel_index),
      .min_pulse(min_pulse_ff), .chan_count(count_ff), .throttle(throttle_ff),
      .frame_gap(gap_ff), .short_limit(short_ff), .job
   );

   rpfd_queue u_queue (
      .clock, .reset, .wr_en(take), .wr_data(job), .full,
      .rd_valid(q_valid), .rd_en(q_valid && q_ready), .rd_data(q_job)
   );

   rpfd_back u_back (
      .clock, .reset, .job_valid(q_valid), .job(q_job), .job_ready(q_ready),
      .min_output(min_out_ff), .max_output(max_out_ff),
      .min_pulse(min_pulse_ff), .max_pulse(max_pulse_ff),
      .res_valid(r_valid), .res_ready(pop),
      .res_frame_done(rsp_frame_done), .res_value(rsp_channel_value),
      .res_failsafe(rsp_failsafe)
   );

   assign empty = !r_valid;

   a_fs_value: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_failsafe |-> rsp_channel_value == FAILSAFE_VALUE)
      else $error("failsafe result without -1");
   a_fs_done: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_failsafe && rsp_frame_done))
      else $error("failsafe and frame_done together");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ===== sv/rpfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpfd_front #(
   parameter int MAX_CHANNELS = rpfd_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [1:0]           op,
   input  wire logic [3:0]           idx,
   input  wire logic [15:0]          min_pulse,
   input  wire logic [4:0]           chan_count,
   input  wire logic [4:0]           throttle,
   input  wire logic [15:0]          frame_gap,
   input  wire logic [15:0]          short_limit,
   output rpfd_pkg::job_type         job
);
   import rpfd_pkg::*;
   localparam int PW = $clog2(MAX_CHANNELS + 1);
   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [15:0]   counter_ff, counter_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          bank_ff, bank_in;
   logic [15:0]   times_ff [2][MAX_CHANNELS];
   logic [PW-1:0] eff_n;
   logic [AW-1:0] wr_addr;
   logic          do_store;
   logic [15:0]   rd_time;
   logic [PW-1:0] ptr_next;

   // clamp channel count
   always_comb begin
      if (chan_count == 5'd0) eff_n = PW'(1);
      else if (32'(chan_count) > MAX_CHANNELS) eff_n = PW'(MAX_CHANNELS);
      else eff_n = PW'(chan_count);
   end

   assign wr_addr  = (32'(ptr_ff) >= MAX_CHANNELS) ? '0 : AW'(ptr_ff);
   assign ptr_next = PW'(wr_addr) + PW'(1);
   assign do_store = take && op == OP_EDGE && counter_ff >= short_limit
                     && counter_ff <= frame_gap;
   assign rd_time  = times_ff[~bank_ff][AW'(idx)];

   always_comb begin
      counter_in = counter_ff;
      ptr_in     = ptr_ff;
      bank_in    = bank_ff;
      job        = '0;
      if (take) begin
         case (op)
            OP_TICK: begin
               if (counter_ff != 16'hFFFF) counter_in = counter_ff + 16'd1;
            end
            OP_EDGE: begin
               if (counter_ff >= short_limit) begin
                  counter_in = '0;
                  if (counter_ff > frame_gap) ptr_in = '0;
                  else if (ptr_next >= eff_n) begin
                     ptr_in         = '0;
                     bank_in        = ~bank_ff;
                     job.frame_done = 1'b1;
                  end else ptr_in = ptr_next;
               end
            end
            OP_READ: begin
               if (PW'(idx) < eff_n) begin
                  if (throttle != 5'd0 && 5'(idx) + 5'd1 == throttle
                      && rd_time < min_pulse) begin
                     job.failsafe = 1'b1;
                     job.value    = FAILSAFE_VALUE;
                  end else begin
                     job.is_map = 1'b1;
                     job.value  = rd_time;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         ptr_ff     <= '0;
         bank_ff    <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         ptr_ff     <= ptr_in;
         bank_ff    <= bank_in;
      end
   end

   // two banks, active one fills; swap copies the rest forward so
   // channels unwritten this frame keep their old value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < 2; b++)
            for (int i = 0; i < MAX_CHANNELS; i++) times_ff[b][i] <= '0;
      end else if (do_store) begin
         times_ff[bank_ff][wr_addr] <= counter_ff;
         if (ptr_next >= eff_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++)
               if (AW'(i) != wr_addr) times_ff[~bank_ff][i] <= times_ff[bank_ff][i];
            times_ff[~bank_ff][wr_addr] <= counter_ff;
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/rpfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpfd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire rpfd_pkg::job_type job,
   output logic                   job_ready,
   input  wire logic [15:0]       min_output,
   input  wire logic [15:0]       max_output,
   input  wire logic [15:0]       min_pulse,
   input  wire logic [15:0]       max_pulse,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output logic                   res_frame_done,
   output logic [15:0]            res_value,
   output logic                   res_failsafe
);
   import rpfd_pkg::*;

   state_type    state_ff, state_in;
   logic [16:0]  dt_ff;       // t - min_pulse, signed
   logic [16:0]  dout_ff;     // max_out - min_out, signed
   logic [16:0]  den_ff;      // |max_pulse - min_pulse|
   logic         neg_ff;
   logic [33:0]  rem_ff;
   logic [33:0]  quo_ff;
   logic [5:0]   cnt_ff;
   logic         out_v_ff;
   logic         fd_ff, fs_ff;
   logic [15:0]  val_ff;

   logic signed [16:0] dpulse;
   logic signed [33:0] prod;
   logic        [34:0] trial;
   logic signed [35:0] sum;
   logic signed [34:0] q_s;
   logic        [15:0] sat;

   assign dpulse = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
   assign prod   = $signed(dt_ff) * $signed(dout_ff);
   assign trial  = {rem_ff, quo_ff[33]} - {18'd0, den_ff};
   assign q_s    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign sum    = 36'(q_s) + 36'($signed(min_output));
   always_comb begin
      if (sum > 36'sd32767) sat = 16'h7FFF;
      else if (sum < -36'sd32768) sat = 16'h8000;
      else sat = sum[15:0];
   end

   assign job_ready = state_ff == ST_IDLE && (!out_v_ff || res_ready);
   assign res_valid      = out_v_ff;
   assign res_frame_done = fd_ff;
   assign res_value      = val_ff;
   assign res_failsafe   = fs_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (job_valid && job_ready && job.is_map) state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == 6'd33) state_in = ST_FIN;
         ST_FIN:  if (!out_v_ff || res_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // datapath: multiply once, then restoring division one bit a cycle
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            dt_ff   <= $signed({1'b0, job.value}) - $signed({1'b0, min_pulse});
            dout_ff <= $signed({max_output[15], max_output})
                       - $signed({min_output[15], min_output});
            den_ff  <= dpulse[16] ? 17'(-dpulse) : 17'(dpulse);
         end
         ST_MUL: begin
            neg_ff <= prod[33] ^ dpulse[16];
            quo_ff <= prod[33] ? 34'(-prod) : 34'(prod);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            if (!trial[34]) rem_ff <= trial[33:0];
            else rem_ff <= {rem_ff[32:0], quo_ff[33]};
            quo_ff <= {quo_ff[32:0], ~trial[34]};
            cnt_ff <= cnt_ff + 6'd1;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (state_ff == ST_IDLE && job_valid && job_ready && !job.is_map)
         out_v_ff <= 1'b1;
      else if (state_ff == ST_FIN && (!out_v_ff || res_ready)) out_v_ff <= 1'b1;
      else if (res_ready) out_v_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && job_valid && job_ready && !job.is_map) begin
         fd_ff  <= job.frame_done;
         fs_ff  <= job.failsafe;
         val_ff <= job.value;
      end else if (state_ff == ST_FIN && (!out_v_ff || res_ready)) begin
         fd_ff  <= 1'b0;
         fs_ff  <= 1'b0;
         val_ff <= (den_ff == 17'd0) ? min_output : sat;
      end
   end
endmodule
`default_nettype wire

// ===== sv/rpfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpfd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire rpfd_pkg::job_type wr_data,
   output logic                   full,
   output logic                   rd_valid,
   input  wire logic              rd_en,
   output rpfd_pkg::job_type      rd_data
);
   import rpfd_pkg::*;
   job_type    slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= ~wp_ff;
         if (rd_en) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_en) - 2'(rd_en);
      end
   end
   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire
